/* hdl/mfut_pkg.sv */
package mfut_pkg;

    // Encoder counts in one mechanical turn of the rotor
    localparam int PULSES_PER_TURN = 8192;

    // Result status codes
    localparam logic [1:0] ST_FRAME  = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_TICK   = 2'd2;

    // Input kinds carried in tuser
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_ID   = 2'd0;
    localparam logic [1:0] CFG_WRAP_THR  = 2'd1;
    localparam logic [1:0] CFG_TMO_LIMIT = 2'd2;

    localparam logic [10:0] BASE_ID_RST   = 11'd513;
    localparam logic [12:0] WRAP_THR_RST  = 13'd4096;
    localparam logic [7:0]  TMO_LIMIT_RST = 8'd10;

    typedef struct packed {
        logic [10:0] base_id;
        logic [12:0] wrap_thr;
        logic [7:0]  tmo_limit;
    } t_cfg;

    // One classified item as it waits in the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic        motor;
        logic [15:0] pos;
        logic [15:0] vel;
        logic [15:0] cur;
        logic [15:0] temp;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* hdl/mfut_front.sv */
module mfut_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfut_pkg::t_cfg      i_cfg,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [79:0]         s_axis_tdata,
    input  logic                s_axis_tuser,
    input  mfut_pkg::t_q_stat   i_q_stat,
    output logic                o_q_push,
    output mfut_pkg::t_item     o_q_item
);
    import mfut_pkg::*;

    logic        r_vld;
    t_item       r_item;
    t_item       n_item;
    logic [10:0] fid;
    logic [11:0] id_lo;
    logic [11:0] id_hi;
    logic        hit_lo;
    logic        hit_hi;

    assign fid    = s_axis_tdata[10:0];
    assign id_lo  = {1'b0, i_cfg.base_id};
    assign id_hi  = id_lo + 12'd1;
    assign hit_lo = ({1'b0, fid} == id_lo);
    assign hit_hi = ({1'b0, fid} == id_hi);

    assign o_q_push      = r_vld && !i_q_stat.full;
    assign s_axis_tready = !r_vld || !i_q_stat.full;
    assign o_q_item      = r_item;

    // Classify and split the payload into words, high byte first
    always_comb begin
        n_item.pos   = {s_axis_tdata[18:11], s_axis_tdata[26:19]};
        n_item.vel   = {s_axis_tdata[34:27], s_axis_tdata[42:35]};
        n_item.cur   = {s_axis_tdata[50:43], s_axis_tdata[58:51]};
        n_item.temp  = {s_axis_tdata[66:59], s_axis_tdata[74:67]};
        n_item.motor = !hit_lo;
        if (s_axis_tuser == CMD_TICK) begin
            n_item.kind = ST_TICK;
        end else if (hit_lo || hit_hi) begin
            n_item.kind = ST_FRAME;
        end else begin
            n_item.kind = ST_IGNORE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

endmodule

/* hdl/mfut_queue.sv */
module mfut_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mfut_pkg::t_item     i_item,
    input  logic                i_pop,
    output mfut_pkg::t_item     o_item,
    output mfut_pkg::t_q_stat   o_stat
);
    import mfut_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hdl/mfut_back.sv */
module mfut_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfut_pkg::t_cfg      i_cfg,
    input  mfut_pkg::t_q_stat   i_q_stat,
    input  mfut_pkg::t_item     i_q_item,
    output logic                o_q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [135:0]        m_axis_tdata,
    output logic [1:0]          m_axis_tuser
);
    import mfut_pkg::*;

    // Per-motor state
    logic [15:0] r_turn [2];
    logic [15:0] r_last [2];
    logic [15:0] r_zero [2];
    logic [1:0]  r_latched;
    logic [7:0]  r_silence [2];
    logic [1:0]  r_tmo;

    // Update stage
    logic               r_a_vld;
    logic [1:0]         r_a_kind;
    logic               r_a_motor;
    logic signed [29:0] r_a_acc;
    logic [15:0]        r_a_vel;
    logic [15:0]        r_a_cur;
    logic [15:0]        r_a_temp;
    logic [1:0]         r_a_tmo;

    // Output stage
    logic               r_o_vld;
    logic [1:0]         r_o_kind;
    logic               r_o_motor;
    logic [29:0]        r_o_acc;
    logic [29:0]        r_o_angle;
    logic [15:0]        r_o_vel;
    logic [15:0]        r_o_cur;
    logic [19:0]        r_o_torque;
    logic [15:0]        r_o_temp;
    logic [1:0]         r_o_tmo;

    logic               o_free;
    logic               a_ready;
    logic               m;
    logic               is_frame;
    logic               is_tick;
    logic [15:0]        last_eff;
    logic [15:0]        zero_eff;
    logic signed [16:0] diff;
    logic signed [17:0] thr;
    logic [15:0]        n_turn;
    logic signed [47:0] acc_full;
    logic [7:0]         n_sil [2];
    logic [1:0]         n_tmo;
    logic signed [36:0] prod;
    logic signed [19:0] torque;

    assign o_free  = !r_o_vld || m_axis_tready;
    assign a_ready = !r_a_vld || o_free;
    assign o_q_pop = !i_q_stat.empty && a_ready;

    assign m        = i_q_item.motor;
    assign is_frame = (i_q_item.kind == ST_FRAME);
    assign is_tick  = (i_q_item.kind == ST_TICK);
    assign last_eff = r_latched[m] ? r_last[m] : i_q_item.pos;
    assign zero_eff = r_latched[m] ? r_zero[m] : i_q_item.pos;
    assign diff     = 17'($signed(i_q_item.pos)) - 17'($signed(last_eff));
    assign thr      = $signed({5'd0, i_cfg.wrap_thr});

    // Step the turn count on a wrap of the single-turn position
    always_comb begin
        n_turn = r_turn[m];
        if (18'(diff) > thr) begin
            n_turn = r_turn[m] - 16'd1;
        end else if (-18'(diff) > thr) begin
            n_turn = r_turn[m] + 16'd1;
        end
    end

    assign acc_full = 48'($signed(n_turn)) * 48'(PULSES_PER_TURN)
                    + 48'($signed(i_q_item.pos)) - 48'($signed(zero_eff));

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_sil[j] = (r_silence[j] == 8'hFF) ? 8'hFF : r_silence[j] + 8'd1;
            n_tmo[j] = r_tmo[j] || (n_sil[j] >= i_cfg.tmo_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 2; j++) begin
                r_turn[j]    <= '0;
                r_last[j]    <= '0;
                r_zero[j]    <= '0;
                r_silence[j] <= '0;
            end
            r_latched <= '0;
            r_tmo     <= '0;
        end else if (o_q_pop) begin
            if (is_tick) begin
                r_silence[0] <= n_sil[0];
                r_silence[1] <= n_sil[1];
                r_tmo        <= n_tmo;
            end else if (is_frame) begin
                r_silence[m] <= '0;
                r_tmo[m]     <= 1'b0;
                r_latched[m] <= 1'b1;
                r_zero[m]    <= zero_eff;
                r_last[m]    <= i_q_item.pos;
                r_turn[m]    <= n_turn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_ready) begin
            r_a_vld <= o_q_pop;
        end
    end

    // Register the item, zero payload unless a frame, and the timeout flags after its update
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_kind  <= i_q_item.kind;
            r_a_motor <= is_frame && m;
            r_a_acc   <= is_frame ? acc_full[29:0] : '0;
            r_a_vel   <= is_frame ? i_q_item.vel : '0;
            r_a_cur   <= is_frame ? i_q_item.cur : '0;
            r_a_temp  <= is_frame ? i_q_item.temp : '0;
            if (is_tick) begin
                r_a_tmo <= n_tmo;
            end else if (is_frame) begin
                r_a_tmo <= m ? {1'b0, r_tmo[0]} : {r_tmo[1], 1'b0};
            end else begin
                r_a_tmo <= r_tmo;
            end
        end
    end

    assign prod   = 37'(r_a_acc) * 37'sd75;
    assign torque = (20'($signed(r_a_cur)) <<< 3) + (20'($signed(r_a_cur)) <<< 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_free) begin
            r_o_vld <= r_a_vld;
        end
    end

    // Floor of acc*75/128 is the arithmetic shift of the product
    always_ff @(posedge i_clk) begin
        if (r_a_vld && o_free) begin
            r_o_kind   <= r_a_kind;
            r_o_motor  <= r_a_motor;
            r_o_acc    <= r_a_acc;
            r_o_angle  <= prod[36:7];
            r_o_vel    <= r_a_vel;
            r_o_cur    <= r_a_cur;
            r_o_torque <= torque;
            r_o_temp   <= r_a_temp;
            r_o_tmo    <= r_a_tmo;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tdata  = {5'd0, r_o_tmo[1], r_o_tmo[0], r_o_temp, r_o_torque,
                            r_o_cur, r_o_vel, r_o_angle, r_o_acc, r_o_motor};

endmodule

/* hdl/motor_feedback_unwrap_timeout.sv */
// Feedback tracker for two motors on one bus. Each input item is either a
// feedback frame (tuser 0) with an identifier and eight data bytes, or a
// monitor tick (tuser 1); every item gives exactly one result item. A frame
// whose identifier equals base_id feeds motor zero and base_id + 1 feeds motor
// one; any other identifier is reported as ignored with zero payload. The
// first frame of a motor sets its zero position; later position jumps beyond
// wrap_threshold step a 16-bit turn count, from which the accumulated pulse
// count and the angle in degrees (Q8) are derived, and the torque (Q15)
// from the current. A tick advances each motor's silence counter and raises
// its timeout flag once the count reaches timeout_limit; a frame clears its
// motor's flag. The block takes one item per clock unless the queue is full:
// the front registers and classifies items, a two-entry queue decouples it
// from the back, where the per-motor state update and the angle multiply sit
// in two register stages. Write the configuration only while no item is in
// flight.
module motor_feedback_unwrap_timeout (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [12:0]  i_cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frame_id, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7
    input  logic [79:0]  s_axis_tdata,
    // command
    input  logic         s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // motor_index, accumulated_pulse, angle_deg_q8, velocity, current,
    // torque_q15, temperature, timeout_motor0, timeout_motor1
    output logic [135:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);
    import mfut_pkg::*;

    t_cfg    r_cfg;
    t_item   front_item;
    t_item   q_item;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    // Always take configuration writes; ignore unknown indexes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_id   <= BASE_ID_RST;
            r_cfg.wrap_thr  <= WRAP_THR_RST;
            r_cfg.tmo_limit <= TMO_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_ID:   r_cfg.base_id   <= i_cfg_data[10:0];
                CFG_WRAP_THR:  r_cfg.wrap_thr  <= i_cfg_data;
                CFG_TMO_LIMIT: r_cfg.tmo_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Accept and classify
    mfut_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_stat      (q_stat),
        .o_q_push      (q_push),
        .o_q_item      (front_item)
    );

    // Hold up to two classified items between the two sides
    mfut_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // Update motor state and build results
    mfut_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_stat      (q_stat),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* hdl/mfut_checker.sv */
module mfut_port_checks (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import mfut_pkg::*;

    // Drop results on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Ticks and ignored frames carry only the timeout flags
    a_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_TICK || m_axis_tuser == ST_IGNORE)
        |-> m_axis_tdata[128:0] == '0)
        else $error("payload on tick or ignored frame");

    // A frame clears its own motor's timeout
    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FRAME
        |-> (m_axis_tdata[0] ? !m_axis_tdata[130] : !m_axis_tdata[129]))
        else $error("frame left its motor timed out");

    // Angle follows the sign of the accumulated count
    a_angle_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FRAME |-> m_axis_tdata[60] == m_axis_tdata[30])
        else $error("angle sign differs from pulse count");

endmodule

bind motor_feedback_unwrap_timeout mfut_port_checks u_mfut_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
